### src/lsrt_pkg.sv
// lsrt_pkg: shared types and constants for the lidar sector range tracker
// holds register indexes, reset values and the configuration bundle
// no dependencies
package lsrt_pkg;

  // default range width in bits
  localparam int RANGE_BITS_DEF = 16;

  // fixed field widths
  localparam int ANGLE_W   = 17;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 12;
  localparam int OUT_W     = 16;

  // samples beyond +180 degrees are dropped
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 17'sd18000;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_WIN_LOW     = 3'd2,
    REG_WIN_HIGH    = 3'd3,
    REG_RANGE_MIN   = 3'd4,
    REG_RANGE_MAX   = 3'd5
  } cfg_idx_e;

  // register reset values
  localparam logic signed [15:0] START_ANGLE_RST = -16'sd18000;
  localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = 12'd100;
  localparam logic signed [15:0] WIN_LOW_RST     = -16'sd9500;
  localparam logic signed [15:0] WIN_HIGH_RST    = -16'sd8500;
  localparam logic [15:0]        RANGE_MIN_RST   = 16'd150;
  localparam logic [15:0]        RANGE_MAX_RST   = 16'd2000;

  // configuration bundle handed to the tracker
  typedef struct packed {
    logic signed [15:0] start_angle;
    logic [STEP_W-1:0]  angle_step;
    logic signed [15:0] win_low;
    logic signed [15:0] win_high;
    logic [15:0]        range_min;
    logic [15:0]        range_max;
  } cfg_t;

endpackage

### src/lsrt_cfg_regs.sv
// lsrt_cfg_regs: configuration register file of the sector range tracker
// depends on lsrt_pkg for indexes, reset values and cfg_t
module lsrt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsrt_pkg::CFG_W-1:0]     cfg_data,
  output lsrt_pkg::cfg_t                 cfg_o
);
  import lsrt_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  // register decode, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_e'(cfg_index))
        REG_START_ANGLE: cfg_nxt.start_angle = $signed(cfg_data);
        REG_ANGLE_STEP:  cfg_nxt.angle_step  = cfg_data[STEP_W-1:0];
        REG_WIN_LOW:     cfg_nxt.win_low     = $signed(cfg_data);
        REG_WIN_HIGH:    cfg_nxt.win_high    = $signed(cfg_data);
        REG_RANGE_MIN:   cfg_nxt.range_min   = cfg_data;
        REG_RANGE_MAX:   cfg_nxt.range_max   = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_angle <= START_ANGLE_RST;
      cfg_r.angle_step  <= ANGLE_STEP_RST;
      cfg_r.win_low     <= WIN_LOW_RST;
      cfg_r.win_high    <= WIN_HIGH_RST;
      cfg_r.range_min   <= RANGE_MIN_RST;
      cfg_r.range_max   <= RANGE_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### src/lsrt_tracker.sv
// lsrt_tracker: per-sample angle, window and range tracking with result register
// depends on lsrt_pkg for cfg_t and angle constants
module lsrt_tracker #(
  parameter int RANGE_BITS = lsrt_pkg::RANGE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lsrt_pkg::cfg_t                 cfg_i,
  // registered sample
  input  logic                           s1_valid,
  input  logic [RANGE_BITS-1:0]          s1_dist,
  input  logic                           s1_no_ret,
  input  logic                           s1_last,
  output logic                           s1_go,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lsrt_pkg::OUT_W-1:0]     out_farthest_mm,
  output logic [lsrt_pkg::OUT_W-1:0]     out_nearest_mm,
  output logic signed [lsrt_pkg::OUT_W-1:0] out_nearest_angle_cdeg
);
  import lsrt_pkg::*;

  localparam int CMP_W = (RANGE_BITS > 16) ? RANGE_BITS : 16;

  logic signed [ANGLE_W-1:0] beam_angle_r, beam_angle_nxt;
  logic                      past_end_r, past_end_nxt;
  logic [RANGE_BITS-1:0]     far_best_r, far_best_nxt;
  logic [RANGE_BITS-1:0]     near_best_r, near_best_nxt;
  logic signed [15:0]        near_angle_r, near_angle_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]          far_out_r, near_out_r;
  logic signed [OUT_W-1:0]   ang_out_r;

  logic                      pe;
  logic                      in_win;
  logic                      out_free;
  logic [CMP_W-1:0]          d_x, rmin_x, rmax_x, far_x, near_x;
  logic signed [ANGLE_W-1:0] wl_x, wh_x;

  // a last item needs a free result register, others never wait
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid && (!s1_last || out_free);

  // operands widened to a common compare width
  assign d_x    = CMP_W'(s1_dist);
  assign rmin_x = CMP_W'(cfg_i.range_min);
  assign rmax_x = CMP_W'(cfg_i.range_max);
  assign far_x  = CMP_W'(far_best_r);
  assign near_x = CMP_W'(near_best_r);
  assign wl_x   = ANGLE_W'(cfg_i.win_low);
  assign wh_x   = ANGLE_W'(cfg_i.win_high);

  assign pe     = past_end_r || (beam_angle_r > ANGLE_LIMIT);
  assign in_win = (beam_angle_r > wl_x) && (beam_angle_r < wh_x);

  // sample evaluation, then end-of-scan clear
  always_comb begin
    beam_angle_nxt = beam_angle_r;
    past_end_nxt   = past_end_r;
    far_best_nxt   = far_best_r;
    near_best_nxt  = near_best_r;
    near_angle_nxt = near_angle_r;
    if (s1_go) begin
      past_end_nxt = pe;
      if (!pe) begin
        if (!s1_no_ret && in_win) begin
          if (d_x > far_x && d_x > rmin_x && d_x < rmax_x) begin
            far_best_nxt = s1_dist;
          end
          if (d_x < near_x && d_x > rmin_x) begin
            near_best_nxt  = s1_dist;
            near_angle_nxt = beam_angle_r[15:0];
          end
        end
        beam_angle_nxt = beam_angle_r + ANGLE_W'({1'b0, cfg_i.angle_step});
      end
    end
  end

  // result register handshake
  always_comb begin
    if (s1_go && s1_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // tracker state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_angle_r <= ANGLE_W'(START_ANGLE_RST);
      past_end_r   <= 1'b0;
      far_best_r   <= '0;
      near_best_r  <= RANGE_BITS'(RANGE_MAX_RST);
      near_angle_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_go && s1_last) begin
        beam_angle_r <= ANGLE_W'(cfg_i.start_angle);
        past_end_r   <= 1'b0;
        far_best_r   <= '0;
        near_best_r  <= RANGE_BITS'(cfg_i.range_max);
        near_angle_r <= '0;
      end else begin
        beam_angle_r <= beam_angle_nxt;
        past_end_r   <= past_end_nxt;
        far_best_r   <= far_best_nxt;
        near_best_r  <= near_best_nxt;
        near_angle_r <= near_angle_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      far_out_r  <= OUT_W'(far_best_nxt);
      near_out_r <= OUT_W'(near_best_nxt);
      ang_out_r  <= near_angle_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_farthest_mm        = far_out_r;
  assign out_nearest_mm         = near_out_r;
  assign out_nearest_angle_cdeg = ang_out_r;

endmodule

### src/lidar_sector_range_tracker.sv
// lidar_sector_range_tracker: top level of the sector range tracker
// instantiates lsrt_cfg_regs and lsrt_tracker, depends on lsrt_pkg
//
// Usage
//   in_*  : one lidar sample per item (distance, no-return flag, end-of-scan
//           mark). Items up to +180 degrees advance the beam angle by the step.
//   out_* : one result item per scan, produced by the item marked
//           last_sample: farthest and nearest qualifying range and the
//           angle of the nearest one.
//   cfg_* : register writes, index as listed in lsrt_pkg, always ready.
//           Write only while no item is in flight.
// Timing
//   An item is registered at acceptance and evaluated when it leaves the input
//   register, where a closing item also loads the result register and raises
//   out_valid. One item per cycle is sustained while no closing item waits on
//   a stalled result register, set by the single compare-and-update pass on
//   the tracker state.
// Reset and stall
//   Reset loads the register defaults and clears the trackers and both
//   stages. While the result register is held by a stalled receiver,
//   samples that do not close a scan keep flowing; a closing item waits in
//   the input register until the result register frees.
module lidar_sector_range_tracker #(
  parameter int RANGE_BITS = lsrt_pkg::RANGE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // sample channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [RANGE_BITS-1:0]          in_distance_mm,
  input  logic                           in_no_return,
  input  logic                           in_last_sample,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lsrt_pkg::OUT_W-1:0]     out_farthest_mm,
  output logic [lsrt_pkg::OUT_W-1:0]     out_nearest_mm,
  output logic signed [lsrt_pkg::OUT_W-1:0] out_nearest_angle_cdeg,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsrt_pkg::CFG_W-1:0]     cfg_data
);
  import lsrt_pkg::*;

  cfg_t                  cfg;
  logic                  s1_valid_r;
  logic [RANGE_BITS-1:0] s1_dist_r;
  logic                  s1_no_ret_r;
  logic                  s1_last_r;
  logic                  s1_go;
  logic                  in_take;

  // input register refills when empty or when its item moves on
  assign in_ready = !s1_valid_r || s1_go;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_dist_r   <= in_distance_mm;
      s1_no_ret_r <= in_no_return;
      s1_last_r   <= in_last_sample;
    end
  end

  // configuration registers
  lsrt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // tracking and result register
  lsrt_tracker #(
    .RANGE_BITS (RANGE_BITS)
  ) u_trk (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_i                  (cfg),
    .s1_valid               (s1_valid_r),
    .s1_dist                (s1_dist_r),
    .s1_no_ret              (s1_no_ret_r),
    .s1_last                (s1_last_r),
    .s1_go                  (s1_go),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_farthest_mm        (out_farthest_mm),
    .out_nearest_mm         (out_nearest_mm),
    .out_nearest_angle_cdeg (out_nearest_angle_cdeg)
  );

endmodule

### src/lsrt_checker.sv
// lsrt_checker: port-level assertions for the sector range tracker
// bound to lidar_sector_range_tracker, depends on lsrt_pkg for widths
module lsrt_checker #(
  parameter int RANGE_BITS = lsrt_pkg::RANGE_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_last_sample,
  input logic [RANGE_BITS-1:0]          in_distance_mm,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lsrt_pkg::OUT_W-1:0]     out_farthest_mm,
  input logic [lsrt_pkg::OUT_W-1:0]     out_nearest_mm,
  input logic signed [lsrt_pkg::OUT_W-1:0] out_nearest_angle_cdeg
);
  import lsrt_pkg::*;

  // a waiting sample item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_distance_mm)
      && $stable(in_last_sample))
    else $error("sample item changed while waiting");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_farthest_mm)
      && $stable(out_nearest_mm) && $stable(out_nearest_angle_cdeg))
    else $error("result item changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a fresh result follows an accepted closing item
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last_sample, 2))
    else $error("result item without a closing sample");

  // samples are never refused while the result side can move
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with a free result register");

endmodule

bind lidar_sector_range_tracker lsrt_checker #(
  .RANGE_BITS (RANGE_BITS)
) u_lsrt_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_ready               (in_ready),
  .in_last_sample         (in_last_sample),
  .in_distance_mm         (in_distance_mm),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_farthest_mm        (out_farthest_mm),
  .out_nearest_mm         (out_nearest_mm),
  .out_nearest_angle_cdeg (out_nearest_angle_cdeg)
);
